// ===== src/cdeq_pkg.sv =====
// Shared types and operation codes for the circular double-ended queue.
package cdeq_pkg;

    // Operation codes carried in the mode field
    localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [2:0] MODE_POP_BACK   = 3'd3;
    localparam logic [2:0] MODE_CLEAR      = 3'd4;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic               accepted;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic [6:0]         count;
        logic               empty_res;
        logic               full_res;
    } rsp_t;

    // Result word handed from the controller to the output stage
    typedef struct packed {
        logic load;
        rsp_t rsp;
    } res_load_t;

endpackage

// ===== src/cdeq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module cdeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/cdeq_ctrl.sv =====
// Pointer, count and end-value control of the deque around the ring RAM.
module cdeq_ctrl #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  cdeq_pkg::req_t             req,
    output logic                       busy,
    output logic                       wr_en,
    output logic [$clog2(DEPTH)-1:0]   wr_addr,
    output logic [DATA_WIDTH-1:0]      wr_data,
    output logic                       rd_en,
    output logic [$clog2(DEPTH)-1:0]   rd_addr,
    input  logic [DATA_WIDTH-1:0]      rd_data,
    output cdeq_pkg::res_load_t        res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cdeq_pkg::state_t      state_reg, state_next;
    logic [AW-1:0]         front_reg, front_next;
    logic [AW-1:0]         back_reg, back_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [DATA_WIDTH-1:0] fval_reg, fval_next;
    logic [DATA_WIDTH-1:0] bval_reg, bval_next;
    logic                  side_front_reg, side_front_next;

    logic                  ok;
    logic                  res_load;
    logic                  is_full;
    logic                  is_empty;
    logic [DATA_WIDTH+31:0] val_ext;
    logic [DATA_WIDTH-1:0]  val_st;
    logic [DATA_WIDTH+31:0] fo_ext;
    logic [DATA_WIDTH+31:0] bo_ext;
    logic [CW+6:0]          cnt_ext;
    logic [AW-1:0]          front_prev, front_succ, back_prev, back_succ;

    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign val_ext  = {{DATA_WIDTH{1'b0}}, req.value};
    assign val_st   = val_ext[DATA_WIDTH-1:0];

    assign front_prev = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - AW'(1);
    assign front_succ = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + AW'(1);
    assign back_prev  = (back_reg == '0) ? AW'(DEPTH - 1) : back_reg - AW'(1);
    assign back_succ  = (back_reg == AW'(DEPTH - 1)) ? '0 : back_reg + AW'(1);

    assign busy = (state_reg != cdeq_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cdeq_pkg::ST_IDLE;
            front_reg      <= '0;
            back_reg       <= '0;
            count_reg      <= '0;
            fval_reg       <= '0;
            bval_reg       <= '0;
            side_front_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            front_reg      <= front_next;
            back_reg       <= back_next;
            count_reg      <= count_next;
            fval_reg       <= fval_next;
            bval_reg       <= bval_next;
            side_front_reg <= side_front_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        count_next      = count_reg;
        fval_next       = fval_reg;
        bval_next       = bval_reg;
        side_front_next = side_front_reg;
        ok              = 1'b0;
        res_load        = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = val_st;
        rd_en           = 1'b0;
        rd_addr         = front_succ;

        unique case (state_reg)
            cdeq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    res_load = 1'b1;
                    unique case (req.mode)
                        cdeq_pkg::MODE_PUSH_FRONT, cdeq_pkg::MODE_PUSH_BACK:
                        begin
                            if (!is_full)
                            begin
                                ok         = 1'b1;
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                                if (is_empty)
                                begin
                                    front_next = '0;
                                    back_next  = '0;
                                    wr_addr    = '0;
                                    fval_next  = val_st;
                                    bval_next  = val_st;
                                end
                                else if (req.mode == cdeq_pkg::MODE_PUSH_FRONT)
                                begin
                                    front_next = front_prev;
                                    wr_addr    = front_prev;
                                    fval_next  = val_st;
                                end
                                else
                                begin
                                    back_next = back_succ;
                                    wr_addr   = back_succ;
                                    bval_next = val_st;
                                end
                            end
                        end
                        cdeq_pkg::MODE_POP_FRONT, cdeq_pkg::MODE_POP_BACK:
                        begin
                            if (!is_empty)
                            begin
                                ok         = 1'b1;
                                count_next = count_reg - CW'(1);
                                if (count_reg == CW'(1))
                                begin
                                    front_next = '0;
                                    back_next  = '0;
                                    fval_next  = '0;
                                    bval_next  = '0;
                                end
                                else
                                begin
                                    // fetch the newly exposed end and report next cycle
                                    res_load   = 1'b0;
                                    rd_en      = 1'b1;
                                    state_next = cdeq_pkg::ST_READ;
                                    if (req.mode == cdeq_pkg::MODE_POP_FRONT)
                                    begin
                                        front_next      = front_succ;
                                        rd_addr         = front_succ;
                                        side_front_next = 1'b1;
                                    end
                                    else
                                    begin
                                        back_next       = back_prev;
                                        rd_addr         = back_prev;
                                        side_front_next = 1'b0;
                                    end
                                end
                            end
                        end
                        cdeq_pkg::MODE_CLEAR:
                        begin
                            ok         = 1'b1;
                            front_next = '0;
                            back_next  = '0;
                            count_next = '0;
                            fval_next  = '0;
                            bval_next  = '0;
                        end
                        default:
                        begin
                            ok = 1'b0;
                        end
                    endcase
                end
            end
            cdeq_pkg::ST_READ:
            begin
                ok         = 1'b1;
                res_load   = 1'b1;
                state_next = cdeq_pkg::ST_IDLE;
                if (side_front_reg)
                begin
                    fval_next = rd_data;
                end
                else
                begin
                    bval_next = rd_data;
                end
            end
            default:
            begin
                state_next = cdeq_pkg::ST_IDLE;
            end
        endcase
    end

    assign fo_ext  = {32'b0, fval_next};
    assign bo_ext  = {32'b0, bval_next};
    assign cnt_ext = {7'b0, count_next};

    assign res.load            = res_load;
    assign res.rsp.accepted    = ok;
    assign res.rsp.front_value = fo_ext[31:0];
    assign res.rsp.back_value  = bo_ext[31:0];
    assign res.rsp.count       = cnt_ext[6:0];
    assign res.rsp.empty_res   = (count_next == '0);
    assign res.rsp.full_res    = (count_next == CW'(DEPTH));

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond capacity");

    a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cdeq_pkg::ST_READ |=> state_reg == cdeq_pkg::ST_IDLE)
        else $error("read wait held longer than one cycle");

    a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cdeq_pkg::ST_READ |-> count_reg != '0)
        else $error("end fetch on an empty queue");

    a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> (fval_reg == '0 && bval_reg == '0 && front_reg == back_reg))
        else $error("empty queue holds stale end values");

endmodule

// ===== src/circular_double_ended_queue.sv =====
// Push, clear, refused and unused operations report in the cycle after start is taken;
// a pop that leaves one or more elements first passes through the read-wait state, as the new end word
// comes back from the ring RAM's registered read port.
// Throughput: one operation per cycle while busy is low; such a pop holds busy high until its end word is in.
// Reset (rst_n low, asynchronous): empty queue, pointers and count at zero, no strobe.
// The receiver cannot stall: each result word shows for exactly one cycle with done high.
module circular_double_ended_queue #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  cdeq_pkg::req_t  req,
    output logic            done,
    output cdeq_pkg::rsp_t  rsp
);

    localparam int AW = $clog2(DEPTH);

    logic                  accept;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;
    cdeq_pkg::res_load_t   res;

    cdeq_pkg::rsp_t        rsp_reg;
    logic                  done_reg;

    // take a word only while no end fetch is outstanding
    assign accept = start && !busy;

    // ring store: one write for a push, one read for a pop that exposes a new end
    cdeq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cdeq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .req     (req),
        .busy    (busy),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .res     (res)
    );

    // strobe: raise for exactly one cycle per result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res.load;
        end
    end

    // result word: hold until the next result replaces it
    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            rsp_reg <= res.rsp;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
